@@ hdl/osf_pkg.sv @@
// shared constants and types for the obstacle steering force block
`timescale 1ns / 1ps
package osf_pkg;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 12;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OBSTACLE_X      = 3'd0,
        REG_OBSTACLE_Y      = 3'd1,
        REG_OBSTACLE_Z      = 3'd2,
        REG_OBSTACLE_RADIUS = 3'd3,
        REG_AVOID_RADIUS    = 3'd4,
        REG_MAX_SPEED       = 3'd5
    } t_cfg_idx;
endpackage

@@ hdl/obstacle_steering_force.sv @@
`timescale 1ns / 1ps
// obstacle steering force: one boid per cycle while the output is not stalled, fully pipelined
// pipeline: five arithmetic stages, COORD_WIDTH+1 root stages,
// 2*COORD_WIDTH-1 divide stages and the output register
// throughput: one transaction per cycle; a stall on the output freezes the whole pipe
// the square root and divide take one result bit per stage
// reset (synchronous, active low) clears valid bits and config registers to 0
module obstacle_steering_force #(
    parameter int COORD_WIDTH = osf_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = osf_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_boid_x,
    input  logic signed [COORD_WIDTH-1:0] i_boid_y,
    input  logic signed [COORD_WIDTH-1:0] i_boid_z,
    input  logic        [COORD_WIDTH-2:0] i_boid_radius,
    input  logic signed [COORD_WIDTH-1:0] i_vel_x,
    input  logic signed [COORD_WIDTH-1:0] i_vel_y,
    input  logic signed [COORD_WIDTH-1:0] i_vel_z,
    input  logic        [COORD_WIDTH-1:0] i_best_distance,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_steer_x,
    output logic signed [COORD_WIDTH-1:0] o_steer_y,
    output logic signed [COORD_WIDTH-1:0] o_steer_z,
    output logic                          o_in_range,
    output logic                          o_contact,
    output logic        [COORD_WIDTH-1:0] o_new_best_distance,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [osf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data
);
    import osf_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int SQW = 2 * W + 2;           // sum of three squares
    localparam int RW  = W + 1;               // root width
    localparam int NW  = 2 * W - 1;           // |d| * max_speed

    // a result-side skid is avoided: the pipe simply holds while the output stalls
    logic w_en;
    assign w_en        = !(o_valid && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic signed [W-1:0] r_obs_x, r_obs_y, r_obs_z;
    logic        [W-2:0] r_obs_rad, r_avoid_rad, r_max_speed;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_x     <= '0;
            r_obs_y     <= '0;
            r_obs_z     <= '0;
            r_obs_rad   <= '0;
            r_avoid_rad <= '0;
            r_max_speed <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_OBSTACLE_X:      r_obs_x     <= i_cfg_data;
                REG_OBSTACLE_Y:      r_obs_y     <= i_cfg_data;
                REG_OBSTACLE_Z:      r_obs_z     <= i_cfg_data;
                REG_OBSTACLE_RADIUS: r_obs_rad   <= i_cfg_data[W-2:0];
                REG_AVOID_RADIUS:    r_avoid_rad <= i_cfg_data[W-2:0];
                REG_MAX_SPEED:       r_max_speed <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [W-1:0] f_sat(input logic signed [W+1:0] v);
        logic signed [W+1:0] smax;
        logic signed [W+1:0] smin;
        smax = (W+2)'((1 << (W-1)) - 1);
        smin = -smax - (W+2)'(1);
        if (v > smax)      f_sat = smax[W-1:0];
        else if (v < smin) f_sat = smin[W-1:0];
        else               f_sat = v[W-1:0];
    endfunction

    // stage 1: saturated difference vector
    logic                r1_vld;
    logic signed [W-1:0] r1_d [3];
    logic signed [W-1:0] r1_vel [3];
    logic        [W-1:0] r1_best;
    logic        [W:0]   r1_rsum, r1_asum;
    logic signed [W-1:0] w_obs [3];
    logic signed [W-1:0] w_boid [3];
    assign w_obs  = '{r_obs_x, r_obs_y, r_obs_z};
    assign w_boid = '{i_boid_x, i_boid_y, i_boid_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (w_en) r1_vld <= i_valid;
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_d[k] <= f_sat((W+2)'(w_obs[k]) - (W+2)'(w_boid[k]));
            end
            r1_vel  <= '{i_vel_x, i_vel_y, i_vel_z};
            r1_best <= i_best_distance;
            r1_rsum <= {1'b0, r_obs_rad} + {1'b0, i_boid_radius};
            r1_asum <= {1'b0, r_avoid_rad} + {1'b0, i_boid_radius};
        end
    end

    // stage 2: magnitudes squared
    logic            r2_vld;
    logic [W-1:0]    r2_mag [3];
    logic [2*W-1:0]  r2_sq [3];
    logic            r2_neg [3];
    logic signed [W-1:0] r2_vel [3];
    logic [W-1:0]    r2_best;
    logic [W:0]      r2_rsum, r2_asum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (w_en) r2_vld <= r1_vld;
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                logic [W-1:0] m;
                m = r1_d[k][W-1] ? W'(-r1_d[k]) : W'(r1_d[k]);
                r2_mag[k] <= m;
                r2_sq[k]  <= m * m;
                r2_neg[k] <= r1_d[k][W-1];
            end
            r2_vel  <= r1_vel;
            r2_best <= r1_best;
            r2_rsum <= r1_rsum;
            r2_asum <= r1_asum;
        end
    end

    // stage 3: sum of squares
    logic           r3_vld;
    logic [SQW-1:0] r3_sum;
    logic [W-1:0]   r3_mag [3];
    logic           r3_neg [3];
    logic signed [W-1:0] r3_vel [3];
    logic [W-1:0]   r3_best;
    logic [W:0]     r3_rsum, r3_asum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (w_en) r3_vld <= r2_vld;
        if (w_en) begin
            r3_sum  <= SQW'(r2_sq[0]) + SQW'(r2_sq[1]) + SQW'(r2_sq[2]);
            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
            r3_vel  <= r2_vel;
            r3_best <= r2_best;
            r3_rsum <= r2_rsum;
            r3_asum <= r2_asum;
        end
    end

    // square root: one root bit per stage, digit-by-digit
    typedef struct packed {
        logic [W-1:0] mag0, mag1, mag2;
        logic         neg0, neg1, neg2;
        logic [W-1:0] vel0, vel1, vel2;
        logic [W-1:0] best;
        logic [W:0]   rsum, asum;
        logic         nz;
    } t_side;

    logic [RW:0]    rs_vld;
    logic [SQW-1:0] rs_rem  [RW+1];
    logic [SQW-1:0] rs_n    [RW+1];
    logic [RW-1:0]  rs_root [RW+1];
    t_side          rs_side [RW+1];

    always_comb begin
        rs_vld[0]  = r3_vld;
        rs_rem[0]  = '0;
        rs_n[0]    = r3_sum;
        rs_root[0] = '0;
        rs_side[0] = '{mag0: r3_mag[0], mag1: r3_mag[1], mag2: r3_mag[2],
                       neg0: r3_neg[0], neg1: r3_neg[1], neg2: r3_neg[2],
                       vel0: r3_vel[0], vel1: r3_vel[1], vel2: r3_vel[2],
                       best: r3_best, rsum: r3_rsum, asum: r3_asum,
                       nz: (r3_sum != '0)};
    end

    for (genvar s = 0; s < RW; s++) begin : g_sqrt
        logic [SQW-1:0] n_rem;
        logic [SQW-1:0] n_trial;
        assign n_rem   = {rs_rem[s][SQW-3:0], rs_n[s][SQW-1 -: 2]};
        assign n_trial = {rs_root[s], 2'b01};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rs_vld[s+1] <= 1'b0;
            else if (w_en) rs_vld[s+1] <= rs_vld[s];
            if (w_en) begin
                rs_n[s+1]    <= {rs_n[s][SQW-3:0], 2'b00};
                rs_side[s+1] <= rs_side[s];
                if (n_rem >= n_trial) begin
                    rs_rem[s+1]  <= n_rem - n_trial;
                    rs_root[s+1] <= {rs_root[s][RW-2:0], 1'b1};
                end else begin
                    rs_rem[s+1]  <= n_rem;
                    rs_root[s+1] <= {rs_root[s][RW-2:0], 1'b0};
                end
            end
        end
    end

    // decision stage
    logic           r4_vld;
    logic [RW-1:0]  r4_len;
    logic           r4_upd, r4_force, r4_contact;
    t_side          r4_side;
    logic [RW-1:0]  w_root;
    t_side          w_sd;
    assign w_root = rs_root[RW];
    assign w_sd   = rs_side[RW];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else if (w_en) r4_vld <= rs_vld[RW];
        if (w_en) begin
            logic upd;
            upd = w_sd.nz && (w_root != '0) && ({1'b0, w_root} < {1'b0, w_sd.asum})
                  && ({2'b00, w_sd.best} < {1'b0, w_root});
            r4_upd     <= upd;
            r4_force   <= upd && (w_root > w_sd.rsum);
            r4_contact <= upd && (w_root == w_sd.rsum);
            r4_len     <= w_root;
            r4_side    <= w_sd;
        end
    end

    // products |d_i| * max_speed
    logic           r5_vld;
    logic [NW-1:0]  r5_prod [3];
    logic [RW-1:0]  r5_len;
    logic           r5_upd, r5_force, r5_contact;
    t_side          r5_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_vld <= 1'b0;
        else if (w_en) r5_vld <= r4_vld;
        if (w_en) begin
            r5_prod[0] <= NW'(r4_side.mag0 * r_max_speed);
            r5_prod[1] <= NW'(r4_side.mag1 * r_max_speed);
            r5_prod[2] <= NW'(r4_side.mag2 * r_max_speed);
            r5_len     <= r4_len;
            r5_upd     <= r4_upd;
            r5_force   <= r4_force;
            r5_contact <= r4_contact;
            r5_side    <= r4_side;
        end
    end

    // three dividers in lockstep, side data rides with lane 0
    typedef struct packed {
        logic         upd, force_on, contact;
        logic [W-1:0] len;
        t_side        side;
    } t_tag;
    localparam int TW = $bits(t_tag);

    t_tag          w_tag_in, w_tag_out;
    logic [NW-1:0] w_q [3];
    logic [2:0]    w_dv;
    logic [RW-1:0] w_den;
    assign w_den    = (r5_len == '0) ? RW'(1) : r5_len;
    assign w_tag_in = '{upd: r5_upd, force_on: r5_force, contact: r5_contact,
                        len: r5_len[W-1:0], side: r5_side};

    for (genvar k = 0; k < 3; k++) begin : g_div
        logic [TW-1:0] w_to;
        osf_steer_div #(.NUM_W(NW), .DEN_W(RW), .TAG_W(TW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r5_vld),
            .i_num   (r5_prod[k]),
            .i_den   (w_den),
            .i_tag   (w_tag_in),
            .o_valid (w_dv[k]),
            .o_quot  (w_q[k]),
            .o_tag   (w_to)
        );
        if (k == 0) begin : g_tag
            assign w_tag_out = t_tag'(w_to);
        end
    end

    // output stage: sign, subtract velocity, saturate; zero force when not in range
    logic signed [W-1:0] r_sx, r_sy, r_sz;
    logic r_vld_o, r_rng, r_con;
    logic [W-1:0] r_best_o;

    function automatic logic signed [W-1:0] f_steer(input logic [NW-1:0] q, input logic neg,
                                                    input logic [W-1:0] vel);
        logic signed [W+1:0] want;
        want = neg ? -(W+2)'(q[W:0]) : (W+2)'(q[W:0]);
        f_steer = f_sat(want - (W+2)'($signed(vel)));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld_o <= 1'b0;
        else if (w_en) r_vld_o <= w_dv[0];
        if (w_en) begin
            if (w_tag_out.force_on) begin
                r_sx <= f_steer(w_q[0], w_tag_out.side.neg0, w_tag_out.side.vel0);
                r_sy <= f_steer(w_q[1], w_tag_out.side.neg1, w_tag_out.side.vel1);
                r_sz <= f_steer(w_q[2], w_tag_out.side.neg2, w_tag_out.side.vel2);
            end else begin
                r_sx <= '0;
                r_sy <= '0;
                r_sz <= '0;
            end
            r_rng    <= w_tag_out.force_on;
            r_con    <= w_tag_out.contact;
            r_best_o <= w_tag_out.upd ? w_tag_out.len : w_tag_out.side.best;
        end
    end

    assign o_valid             = r_vld_o;
    assign o_steer_x           = r_sx;
    assign o_steer_y           = r_sy;
    assign o_steer_z           = r_sz;
    assign o_in_range          = r_rng;
    assign o_contact           = r_con;
    assign o_new_best_distance = r_best_o;
endmodule

@@ hdl/osf_steer_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module osf_steer_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 24,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic [TAG_W-1:0] o_tag
);
    logic [NUM_W:0]   r_vld;
    logic [NUM_W-1:0] r_q   [NUM_W+1];
    logic [DEN_W:0]   r_rem [NUM_W+1];
    logic [DEN_W-1:0] r_den [NUM_W+1];
    logic [TAG_W-1:0] r_tag [NUM_W+1];

    always_comb begin
        r_vld[0] = i_valid;
        r_q[0]   = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W+1:0] n_trial;
        logic [DEN_W+1:0] n_shift;
        assign n_shift = {r_rem[s], r_q[s][NUM_W-1]};
        assign n_trial = n_shift - {2'b00, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
                if (!n_trial[DEN_W+1]) begin
                    r_rem[s+1] <= n_trial[DEN_W:0];
                    r_q[s+1]   <= {r_q[s][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= n_shift[DEN_W:0];
                    r_q[s+1]   <= {r_q[s][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_q[NUM_W];
    assign o_tag   = r_tag[NUM_W];
endmodule

@@ hdl/osf_checker.sv @@
// port-level checks for the obstacle steering force block
`timescale 1ns / 1ps
module osf_checker #(
    parameter int COORD_WIDTH = osf_pkg::COORD_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic                   o_stall,
    input logic                   o_in_range,
    input logic                   o_contact,
    input logic [COORD_WIDTH-1:0] o_steer_x
);
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_in_range && o_contact)) else $error("in_range with contact");
    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_steer_x == '0)) else $error("force without range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_steer_x)) else $error("result dropped");
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)) else $error("stall without cause");
endmodule

bind obstacle_steering_force osf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_osf_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_stall(o_stall), .o_in_range(o_in_range), .o_contact(o_contact),
    .o_steer_x(o_steer_x)
);

@@ tb/obstacle_steering_force_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the obstacle steering force block
module obstacle_steering_force_test;
    import osf_pkg::*;

    localparam int W         = COORD_WIDTH_DEF;
    localparam int PIPE_LAT  = 6 + W + 2 * W - 1 + 1;
    localparam int IDLE_LIMIT = 20000;
    localparam longint SMAX  = (64'sd1 <<< (W - 1)) - 1;
    localparam longint SMIN  = -SMAX - 1;

    // one boid and the force it should produce
    typedef struct {
        logic signed [W-1:0] bx, by, bz;
        logic        [W-2:0] br;
        logic signed [W-1:0] vx, vy, vz;
        logic        [W-1:0] best;
    } t_boid;

    typedef struct {
        logic signed [W-1:0] sx, sy, sz;
        logic                in_range;
        logic                contact;
        logic        [W-1:0] best;
    } t_force;

    // holds the forces still owed by the block, worked out from its own copy of the registers
    class t_force_board;
        logic signed [W-1:0] obs[3];
        logic [W-2:0] obs_rad, avoid_rad, speed;
        t_force owed[$];
        int errors;
        int checked;
        int n_range, n_contact, n_update;

        function new();
            obs = '{0, 0, 0};
            obs_rad = 0; avoid_rad = 0; speed = 0;
            errors = 0; checked = 0;
            n_range = 0; n_contact = 0; n_update = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [W-1:0] val);
            case (idx)
                REG_OBSTACLE_X:      obs[0] = val;
                REG_OBSTACLE_Y:      obs[1] = val;
                REG_OBSTACLE_Z:      obs[2] = val;
                REG_OBSTACLE_RADIUS: obs_rad = val[W-2:0];
                REG_AVOID_RADIUS:    avoid_rad = val[W-2:0];
                REG_MAX_SPEED:       speed = val[W-2:0];
                default: ;
            endcase
        endfunction

        static function longint clip(longint v);
            if (v > SMAX) return SMAX;
            if (v < SMIN) return SMIN;
            return v;
        endfunction

        static function longint unsigned floor_root(longint unsigned n);
            longint unsigned root, bit_v;
            root = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > n) bit_v >>= 2;
            while (bit_v != 0) begin
                if (n >= root + bit_v) begin
                    n -= root + bit_v;
                    root = (root >> 1) + bit_v;
                end else begin
                    root >>= 1;
                end
                bit_v >>= 2;
            end
            return root;
        endfunction

        function void note_boid(t_boid b);
            longint d[3], vel[3], st[3];
            longint unsigned m, sq, len, q, lim_av, lim_ob;
            longint pos[3];
            t_force f;
            pos[0] = b.bx; pos[1] = b.by; pos[2] = b.bz;
            vel[0] = b.vx; vel[1] = b.vy; vel[2] = b.vz;
            st = '{0, 0, 0};
            sq = 0;
            f.in_range = 0; f.contact = 0;
            f.best = b.best;
            for (int i = 0; i < 3; i++) begin
                d[i] = clip(longint'(obs[i]) - pos[i]);
                m = d[i] < 0 ? -d[i] : d[i];
                sq += m * m;
            end
            if (sq != 0) begin
                len = floor_root(sq);
                lim_av = longint'(avoid_rad) + longint'(b.br);
                lim_ob = longint'(obs_rad) + longint'(b.br);
                if (len != 0 && len < lim_av && longint'(b.best) < len) begin
                    f.best = len[W-1:0];
                    n_update++;
                    if (len > lim_ob) begin
                        f.in_range = 1;
                        n_range++;
                        for (int i = 0; i < 3; i++) begin
                            m = d[i] < 0 ? -d[i] : d[i];
                            q = (m * longint'(speed)) / len;
                            st[i] = clip((d[i] < 0 ? -longint'(q) : longint'(q)) - vel[i]);
                        end
                    end else if (len == lim_ob) begin
                        f.contact = 1;
                        n_contact++;
                    end
                end
            end
            f.sx = st[0]; f.sy = st[1]; f.sz = st[2];
            owed.push_back(f);
        endfunction

        function void check_force(t_force got);
            t_force e;
            if (owed.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = owed.pop_front();
            checked++;
            if (got.sx !== e.sx) begin
                $error("steer_x expected %0d got %0d", e.sx, got.sx); errors++;
            end
            if (got.sy !== e.sy) begin
                $error("steer_y expected %0d got %0d", e.sy, got.sy); errors++;
            end
            if (got.sz !== e.sz) begin
                $error("steer_z expected %0d got %0d", e.sz, got.sz); errors++;
            end
            if (got.in_range !== e.in_range) begin
                $error("in_range expected %0b got %0b", e.in_range, got.in_range); errors++;
            end
            if (got.contact !== e.contact) begin
                $error("contact expected %0b got %0b", e.contact, got.contact); errors++;
            end
            if (got.best !== e.best) begin
                $error("new_best_distance expected %0d got %0d", e.best, got.best);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic signed [W-1:0] i_boid_x, i_boid_y, i_boid_z, i_vel_x, i_vel_y, i_vel_z;
    logic [W-2:0] i_boid_radius;
    logic [W-1:0] i_best_distance, o_new_best_distance;
    logic signed [W-1:0] o_steer_x, o_steer_y, o_steer_z;
    logic o_in_range, o_contact;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [W-1:0] i_cfg_data;

    obstacle_steering_force uut (.*);

    t_force_board board = new();

    // receiver behaviour, set by the stimulus process
    bit hold_off = 0;
    bit sink_gaps = 1;
    int idle_cycles = 0;
    int items_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        {i_boid_x, i_boid_y, i_boid_z, i_boid_radius} = '0;
        {i_vel_x, i_vel_y, i_vel_z, i_best_distance} = '0;
    end

    // short gaps mostly, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: check every accepted transaction
    always @(posedge i_clk) begin
        t_force got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.sx = o_steer_x; got.sy = o_steer_y; got.sz = o_steer_z;
            got.in_range = o_in_range; got.contact = o_contact;
            got.best = o_new_best_distance;
            board.check_force(got);
        end
    end

    // stall pattern lives in its own process, counted in cycles
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                i_stall <= 1'b1;
                @(posedge i_clk);
            end else if (sink_gaps) begin
                n = gap_len();
                i_stall <= (n != 0);
                repeat (n == 0 ? $urandom_range(1, 6) : n) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // valid stays up across a run of writes, set_obstacle drops it at the end
    task automatic write_reg(t_cfg_idx idx, logic [W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, val);
    endtask

    // wait for every owed force, then let the pipe drain fully
    task automatic drain();
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic set_obstacle(logic [W-1:0] ox, oy, oz, logic [W-2:0] orad, arad, spd);
        write_reg(REG_OBSTACLE_X, ox);
        write_reg(REG_OBSTACLE_Y, oy);
        write_reg(REG_OBSTACLE_Z, oz);
        write_reg(REG_OBSTACLE_RADIUS, orad);
        write_reg(REG_AVOID_RADIUS, arad);
        write_reg(REG_MAX_SPEED, spd);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one boid, hold it steady until taken, optional gap first
    task automatic send_boid(t_boid b, bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_boid_x <= b.bx; i_boid_y <= b.by; i_boid_z <= b.bz;
        i_boid_radius <= b.br;
        i_vel_x <= b.vx; i_vel_y <= b.vy; i_vel_z <= b.vz;
        i_best_distance <= b.best;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_boid(b);
        items_sent++;
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [W-1:0] rnd_word();
        return $urandom();
    endfunction

    // small signed offset around a centre, wrapping kept out of the way
    function automatic logic signed [W-1:0] near(logic signed [W-1:0] c, int span);
        longint v;
        v = longint'(c) + $urandom_range(0, 2 * span) - span;
        return boid_board_clip(v);
    endfunction

    function automatic logic signed [W-1:0] boid_board_clip(longint v);
        return t_force_board::clip(v);
    endfunction

    // boid placed so that the interesting regions around the obstacle are hit often
    function automatic t_boid shaped_boid();
        t_boid b;
        int mode, span;
        longint unsigned lim;
        mode = $urandom_range(0, 9);
        b.br = $urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 4096);
        lim = longint'(board.avoid_rad) + b.br;
        span = (lim > 64'd2000000) ? 2000000 : int'(lim) + 1;
        if (mode < 7) begin
            b.bx = near(board.obs[0], span / 2);
            b.by = near(board.obs[1], span / 2);
            b.bz = near(board.obs[2], span / 2);
        end else if (mode < 8) begin
            // on an axis at exactly the solid radius
            lim = longint'(board.obs_rad) + b.br;
            b.bx = boid_board_clip(longint'(board.obs[0]) - longint'(lim));
            b.by = board.obs[1];
            b.bz = board.obs[2];
        end else begin
            b.bx = rnd_word(); b.by = rnd_word(); b.bz = rnd_word();
        end
        b.vx = rnd_word(); b.vy = rnd_word(); b.vz = rnd_word();
        if ($urandom_range(0, 3) == 0) begin
            b.vx = near(0, 4096); b.vy = near(0, 4096); b.vz = near(0, 4096);
        end
        case ($urandom_range(0, 3))
            0: b.best = rnd_word();
            1: b.best = '0;
            default: b.best = $urandom_range(0, 8192);
        endcase
        return b;
    endfunction

    function automatic t_boid mk(longint x, y, z, r, vx, vy, vz, best);
        t_boid b;
        b.bx = x; b.by = y; b.bz = z; b.br = r;
        b.vx = vx; b.vy = vy; b.vz = vz; b.best = best;
        return b;
    endfunction

    initial begin
        t_boid b;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: obstacle at origin, solid 1.0, avoid 4.0, speed 2.0
        set_obstacle(0, 0, 0, 24'd4096, 24'd16384, 24'd8192);
        send_boid(mk(0, 0, 0, 0, 5, 5, 5, 7), 0);                    // coincident
        send_boid(mk(8192, 0, 0, 0, 0, 0, 0, 0), 0);                 // in range, +x
        send_boid(mk(0, -8192, 0, 0, 100, -100, 3, 0), 0);           // in range, -y
        send_boid(mk(0, 0, 4096, 0, 0, 0, 0, 0), 0);                 // contact
        send_boid(mk(2048, 0, 0, 0, 0, 0, 0, 0), 0);                 // inside the solid
        send_boid(mk(2048, 0, 0, 2048, 0, 0, 0, 0), 0);              // inside the solid, boid radius added
        send_boid(mk(20000, 0, 0, 0, 0, 0, 0, 0), 0);                // beyond avoid radius
        send_boid(mk(8192, 0, 0, 0, 0, 0, 0, 8192), 0);              // record not beaten
        send_boid(mk(8192, 0, 0, 0, 0, 0, 0, 8191), 0);              // record just beaten
        send_boid(mk(8192, 0, 0, 0, SMIN, SMAX, SMIN, 0), 0);        // force saturation
        send_boid(mk(SMAX, SMAX, SMAX, 0, 0, 0, 0, 24'hffffff), 0);  // far corner
        send_boid(mk(SMIN, SMIN, SMIN, 23'h7fffff, SMAX, SMAX, SMAX, 0), 0);
        send_boid(mk(1, 0, 0, 0, 0, 0, 0, 0), 0);                    // tiny offset, len 1
        stop_sending();
        drain();

        // extremes: far obstacle, zero solid radius, widest avoid radius, top speed
        set_obstacle(SMAX, SMIN, SMAX, 0, 23'h7fffff, 23'h7fffff);
        send_boid(mk(SMIN, SMAX, SMIN, 23'h7fffff, 0, 0, 0, 0), 0);  // far difference
        send_boid(mk(SMAX - 4096, SMIN, SMAX, 0, SMIN, 0, SMAX, 0), 0);
        send_boid(mk(SMAX, SMIN, SMAX, 0, 1, 1, 1, 0), 0);           // coincident
        send_boid(mk(0, 0, 0, 100, -1, -1, -1, 1), 0);
        send_boid(mk(SMAX, SMIN + 1, SMAX - 1, 0, 0, 0, 0, 0), 0);
        stop_sending();
        drain();

        // random phases, each with a fresh obstacle setting
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: set_obstacle(near(0, 40000), near(0, 40000), near(0, 40000),
                                $urandom_range(0, 8192), $urandom_range(8192, 65536),
                                $urandom_range(0, 16384));
                1: set_obstacle(rnd_word(), rnd_word(), rnd_word(),
                                $urandom(), $urandom(), $urandom());
                2: set_obstacle(SMIN, SMAX, 0, $urandom_range(0, 2048),
                                23'h7fffff, 23'h7fffff);
                default: set_obstacle(rnd_word(), rnd_word(), rnd_word(),
                                      0, $urandom_range(4096, 200000), 0);
            endcase
            sink_gaps = (phase != 5);  // one phase runs with the receiver always ready
            for (int n = 0; n < 200; n++) begin
                if (phase == 2 && n == 20) begin
                    // receiver holds off long enough to fill the pipe and stall the input
                    hold_off = 1;
                    fork
                        begin
                            repeat (3 * PIPE_LAT) @(posedge i_clk);
                            hold_off = 0;
                        end
                    join_none
                end
                b = shaped_boid();
                send_boid(b, phase != 4);
            end
            stop_sending();
            drain();
        end

        $display("covered %0d boids: %0d in range, %0d contact, %0d record updates",
                 items_sent, board.n_range, board.n_contact, board.n_update);
        $display("%0d results checked over 10 obstacle settings", board.checked);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
